// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the color converter.
// Self-contained; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Fails at any clock edge out of reset where the condition holds.
`define ASSERT_NEVER(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("forbidden condition seen");
// Fails when the antecedent holds and the consequent does not at the same edge.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define ASSERT_NEVER(label, ck, rn, cond)
`define ASSERT_IMPLIES(label, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/hhr_pkg.sv -----
// Types and constants of the HSV/HSL/HWB to RGB converter.
// No dependencies; used by the top level.
package hhr_pkg;

    localparam int HUE_BITS    = 16;
    localparam int ALPHA_BITS  = 8;
    localparam int CHAN_BITS   = 8;
    localparam int SECTOR_BITS = 3;
    // In-sector hue weight, up to 65536 inclusive.
    localparam int FRAC_BITS   = 17;
    localparam int FRAC_SHIFT  = 16;
    localparam int MODEL_BITS  = 2;

    typedef logic [MODEL_BITS-1:0] model_t;

    localparam model_t MODEL_HSV = 2'd0;
    localparam model_t MODEL_HSL = 2'd1;
    localparam model_t MODEL_HWB = 2'd2;

    typedef logic [SECTOR_BITS-1:0] sector_t;

    localparam sector_t SEC_RED_YEL = 3'd0;
    localparam sector_t SEC_YEL_GRN = 3'd1;
    localparam sector_t SEC_GRN_CYN = 3'd2;
    localparam sector_t SEC_CYN_BLU = 3'd3;
    localparam sector_t SEC_BLU_MAG = 3'd4;
    localparam sector_t SEC_MAG_RED = 3'd5;

    // Red sits in the lowest bits so the struct maps straight onto tdata.
    typedef struct packed {
        logic [CHAN_BITS-1:0]  alpha;
        logic [CHAN_BITS-1:0]  blue;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  red;
    } pixel_t;

endpackage

// ----- rtl/hhr_div.sv -----
// Pipelined restoring divider for the saturation of the converter.
// Stand-alone module; one quotient bit per register stage.
module hhr_div #(
    parameter int W  = 16,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  quo,
    output logic [PW-1:0] out_side
);

    // Computes num * (2^W - 1) / den, valid for 0 < num <= den.
    // The dividend is (num - 1) * 2^W + (2^W - num), so its upper half is
    // already below den and W shift-subtract steps give the whole quotient.
    // Quotient bits shift into the low half as dividend bits leave it.

    logic [2*W-1:0] part_reg [W];
    logic [W-1:0]   den_reg  [W-1];
    logic [PW-1:0]  side_reg [W];
    logic           vld_reg  [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [2*W-1:0] part_in;
        logic [W-1:0]   den_in;
        logic [PW-1:0]  side_in;
        logic           vld_in;
        logic [W:0]     trial;
        logic [W:0]     diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign part_in = {num - W'(1), ~num + W'(1)};
            assign den_in  = den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign part_in = part_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign trial = part_in[2*W-1:W-1];
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                part_reg[k] <= {(ge ? diff[W-1:0] : trial[W-1:0]), part_in[W-2:0], ge};
                side_reg[k] <= side_in;
            end
        end

        if (k < W - 1) begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[W-1];
    assign quo       = part_reg[W-1][W-1:0];
    assign out_side  = side_reg[W-1];

endmodule

// ----- rtl/hsv_hsl_hwb_to_rgb.sv -----
// HSV / HSL / HWB to 8-bit RGB converter, one pixel per item, built on hhr_pkg and
// hhr_div. The source_model register (written through cfg_wr_en / cfg_wr_data) picks
// the input model: 0 HSV, 1 HSL, 2 HWB, and 3 behaves as HSV. Hue is a 16-bit fraction
// of a full turn and the two components are COMPONENT_BITS-bit fractions where all ones
// is 1.0; alpha passes through. The pipeline takes one item in every cycle while s_tready
// is high. A result passes through stages 1 to 4, the saturation divider, stages 5 to 10
// and the output register; the divider resolves one quotient bit per stage. When
// m_tready is low the output register holds and a single skid entry catches the next
// result, so s_tready falls only once that entry is full.
`include "assert_macros.svh"

module hsv_hsl_hwb_to_rgb #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  hhr_pkg::model_t        cfg_wr_data,   // source_model
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // hue, first_component, second_component, alpha, zero fill to whole bytes
    input  logic [((hhr_pkg::HUE_BITS + 2*COMPONENT_BITS + hhr_pkg::ALPHA_BITS + 7)/8)*8-1:0]
                                   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output hhr_pkg::pixel_t        m_tdata        // red, green, blue, alpha_out
);

    localparam int W   = COMPONENT_BITS;
    localparam int W2  = 2 * COMPONENT_BITS;
    localparam int FB  = hhr_pkg::FRAC_BITS;
    localparam int HB  = hhr_pkg::HUE_BITS;
    localparam int AB  = hhr_pkg::ALPHA_BITS;
    localparam int CB  = hhr_pkg::CHAN_BITS;
    localparam logic [W-1:0] ONE = {W{1'b1}};

    typedef logic [W-1:0]  comp_t;
    typedef logic [W2-1:0] wide_t;
    typedef logic [AB-1:0] alpha_t;
    typedef logic [FB-1:0] frac_t;

    typedef struct packed {
        hhr_pkg::model_t  model;
        comp_t            first;
        comp_t            second;
        comp_t            lo;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } s1_t;

    typedef struct packed {
        hhr_pkg::model_t  model;
        comp_t            first;
        comp_t            second;
        wide_t            prod;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } s2_t;

    typedef struct packed {
        hhr_pkg::model_t  model;
        comp_t            first;
        comp_t            second;
        comp_t            pl;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } s3_t;

    typedef struct packed {
        comp_t            v;
        logic             direct;
        comp_t            dsat;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } side_t;

    typedef struct packed {
        comp_t a;
        side_t side;
    } s4_t;

    typedef struct packed {
        wide_t            cprod;
        comp_t            v;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } s5_t;

    typedef struct packed {
        comp_t            c;
        comp_t            v;
        hhr_pkg::sector_t sector;
        frac_t            fsel;
        alpha_t           alpha;
    } s6_t;

    typedef struct packed {
        comp_t            c;
        comp_t            m;
        logic [W+FB-1:0]  xprod;
        hhr_pkg::sector_t sector;
        alpha_t           alpha;
    } s7_t;

    typedef struct packed {
        comp_t  r;
        comp_t  g;
        comp_t  b;
        alpha_t alpha;
    } s8_t;

    typedef struct packed {
        logic [W+CB-1:0] r;
        logic [W+CB-1:0] g;
        logic [W+CB-1:0] b;
        alpha_t          alpha;
    } s9_t;

    // Exact x / (2^W - 1) for x up to ONE * ONE: the estimate x >> W is low by at
    // most two, and the remainder low + hi tells by how much.
    function automatic comp_t div_one(input wide_t x);
        comp_t        hi;
        logic [W+1:0] r;
        hi = x[W2-1:W];
        r  = {2'b00, x[W-1:0]} + {2'b00, hi};
        return hi + W'(r >= {2'b00, ONE}) + W'(r >= {1'b0, ONE, 1'b0});
    endfunction

    hhr_pkg::model_t model_reg;

    logic en;
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic p5_valid_reg, p6_valid_reg, p7_valid_reg, p8_valid_reg;
    logic p9_valid_reg, p10_valid_reg;

    s1_t p1_reg, p1_next;
    s2_t p2_reg, p2_next;
    s3_t p3_reg, p3_next;
    s4_t p4_reg, p4_next;
    s5_t p5_reg, p5_next;
    s6_t p6_reg, p6_next;
    s7_t p7_reg, p7_next;
    s8_t p8_reg, p8_next;
    s9_t p9_reg, p9_next;
    hhr_pkg::pixel_t p10_reg, p10_next;

    logic            div_valid;
    comp_t           div_quo;
    logic [$bits(side_t)-1:0] div_side_bits;
    side_t           div_side;

    hhr_pkg::pixel_t out_reg, skid_reg;
    logic            out_valid_reg, skid_valid_reg;
    logic            last_fire, out_free;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg <= hhr_pkg::MODEL_HSV;
        end
        else if (cfg_wr_en)
        begin
            model_reg <= cfg_wr_data;
        end
    end

    // The whole pipeline moves together; it stops only while the skid entry is full.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------- stage 1
    logic [HB-1:0] in_hue;
    logic [HB+2:0] hue6;
    comp_t         in_second;

    always_comb
    begin
        in_hue    = s_tdata[HB-1:0];
        in_second = s_tdata[HB+W +: W];
        hue6      = ({3'b000, in_hue} << 2) + ({3'b000, in_hue} << 1);

        p1_next.model  = model_reg;
        p1_next.first  = s_tdata[HB +: W];
        p1_next.second = in_second;
        p1_next.lo     = (in_second <= ONE - in_second) ? in_second : ONE - in_second;
        p1_next.sector = hue6[HB+2:HB];
        // Odd sectors ramp down, so their weight is one minus the fraction.
        p1_next.fsel   = hue6[HB] ? (frac_t'(1) << hhr_pkg::FRAC_SHIFT) - {1'b0, hue6[HB-1:0]}
                                  : {1'b0, hue6[HB-1:0]};
        p1_next.alpha  = s_tdata[HB+2*W +: AB];
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        p2_next.model  = p1_reg.model;
        p2_next.first  = p1_reg.first;
        p2_next.second = p1_reg.second;
        p2_next.prod   = W2'(p1_reg.first) * W2'(p1_reg.lo);
        p2_next.sector = p1_reg.sector;
        p2_next.fsel   = p1_reg.fsel;
        p2_next.alpha  = p1_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 3
    always_comb
    begin
        p3_next.model  = p2_reg.model;
        p3_next.first  = p2_reg.first;
        p3_next.second = p2_reg.second;
        p3_next.pl     = div_one(p2_reg.prod);
        p3_next.sector = p2_reg.sector;
        p3_next.fsel   = p2_reg.fsel;
        p3_next.alpha  = p2_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 4
    // Value and the saturation numerator; cases with a known saturation bypass
    // the divider through the direct flag.
    always_comb
    begin
        p4_next.side.sector = p3_reg.sector;
        p4_next.side.fsel   = p3_reg.fsel;
        p4_next.side.alpha  = p3_reg.alpha;
        unique case (p3_reg.model)
            hhr_pkg::MODEL_HSL:
            begin
                p4_next.side.v      = p3_reg.second + p3_reg.pl;
                p4_next.a           = {p3_reg.pl[W-2:0], 1'b0};
                p4_next.side.direct = (p3_reg.pl == '0);
                p4_next.side.dsat   = '0;
            end
            hhr_pkg::MODEL_HWB:
            begin
                p4_next.side.v      = ONE - p3_reg.second;
                p4_next.a           = (ONE - p3_reg.second) - p3_reg.first;
                p4_next.side.direct = (p3_reg.first >= ONE - p3_reg.second);
                p4_next.side.dsat   = '0;
            end
            default:
            begin
                p4_next.side.v      = p3_reg.second;
                p4_next.a           = p3_reg.second;
                p4_next.side.direct = 1'b1;
                p4_next.side.dsat   = p3_reg.first;
            end
        endcase
    end

    // ---------------------------------------------------------------- divider
    hhr_div #(
        .W  (W),
        .PW ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .num       (p4_reg.a),
        .den       (p4_reg.side.v),
        .in_side   (p4_reg.side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side_bits)
    );

    assign div_side = div_side_bits;

    // ---------------------------------------------------------------- stage 5
    comp_t sat;

    always_comb
    begin
        sat            = div_side.direct ? div_side.dsat : div_quo;
        p5_next.cprod  = W2'(sat) * W2'(div_side.v);
        p5_next.v      = div_side.v;
        p5_next.sector = div_side.sector;
        p5_next.fsel   = div_side.fsel;
        p5_next.alpha  = div_side.alpha;
    end

    // ---------------------------------------------------------------- stage 6
    always_comb
    begin
        p6_next.c      = div_one(p5_reg.cprod);
        p6_next.v      = p5_reg.v;
        p6_next.sector = p5_reg.sector;
        p6_next.fsel   = p5_reg.fsel;
        p6_next.alpha  = p5_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 7
    always_comb
    begin
        p7_next.c      = p6_reg.c;
        p7_next.m      = p6_reg.v - p6_reg.c;
        p7_next.xprod  = (W+FB)'(p6_reg.c) * (W+FB)'(p6_reg.fsel);
        p7_next.sector = p6_reg.sector;
        p7_next.alpha  = p6_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 8
    comp_t x, ch_r, ch_g, ch_b;

    always_comb
    begin
        x    = p7_reg.xprod[hhr_pkg::FRAC_SHIFT +: W];
        ch_r = '0;
        ch_g = '0;
        ch_b = '0;
        case (p7_reg.sector)
            hhr_pkg::SEC_RED_YEL:
            begin
                ch_r = p7_reg.c;
                ch_g = x;
            end
            hhr_pkg::SEC_YEL_GRN:
            begin
                ch_r = x;
                ch_g = p7_reg.c;
            end
            hhr_pkg::SEC_GRN_CYN:
            begin
                ch_g = p7_reg.c;
                ch_b = x;
            end
            hhr_pkg::SEC_CYN_BLU:
            begin
                ch_g = x;
                ch_b = p7_reg.c;
            end
            hhr_pkg::SEC_BLU_MAG:
            begin
                ch_r = x;
                ch_b = p7_reg.c;
            end
            default:
            begin
                ch_r = p7_reg.c;
                ch_b = x;
            end
        endcase
        // Channel plus offset never exceeds the value, so W bits hold the sum.
        p8_next.r     = ch_r + p7_reg.m;
        p8_next.g     = ch_g + p7_reg.m;
        p8_next.b     = ch_b + p7_reg.m;
        p8_next.alpha = p7_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 9
    always_comb
    begin
        p9_next.r     = {p8_reg.r, 8'h00} - {8'h00, p8_reg.r};
        p9_next.g     = {p8_reg.g, 8'h00} - {8'h00, p8_reg.g};
        p9_next.b     = {p8_reg.b, 8'h00} - {8'h00, p8_reg.b};
        p9_next.alpha = p8_reg.alpha;
    end

    // ---------------------------------------------------------------- stage 10
    comp_t q_r, q_g, q_b;

    always_comb
    begin
        q_r            = div_one(W2'(p9_reg.r));
        q_g            = div_one(W2'(p9_reg.g));
        q_b            = div_one(W2'(p9_reg.b));
        p10_next.red   = q_r[CB-1:0];
        p10_next.green = q_g[CB-1:0];
        p10_next.blue  = q_b[CB-1:0];
        p10_next.alpha = p9_reg.alpha;
    end

    // ---------------------------------------------------------------- pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_valid_reg  <= 1'b0;
            p8_valid_reg  <= 1'b0;
            p9_valid_reg  <= 1'b0;
            p10_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= s_tvalid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= div_valid;
            p6_valid_reg  <= p5_valid_reg;
            p7_valid_reg  <= p6_valid_reg;
            p8_valid_reg  <= p7_valid_reg;
            p9_valid_reg  <= p8_valid_reg;
            p10_valid_reg <= p9_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p4_next;
            p5_reg  <= p5_next;
            p6_reg  <= p6_next;
            p7_reg  <= p7_next;
            p8_reg  <= p8_next;
            p9_reg  <= p9_next;
            p10_reg <= p10_next;
        end
    end

    // ---------------------------------------------------------------- output and skid
    // The skid entry always holds the item right behind the one in the output register.
    assign last_fire = en && p10_valid_reg;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_fire;
            end
        end
        else if (last_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (last_fire)
            begin
                out_reg <= p10_reg;
            end
        end
        else if (last_fire)
        begin
            skid_reg <= p10_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // ---------------------------------------------------------------- assertions
    `ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg)
    `ASSERT_IMPLIES(a_skid_fills_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready))
    `ASSERT_IMPLIES(a_div_operands, clk, rst_n, p4_valid_reg && !p4_reg.side.direct, (p4_reg.a != '0) && (p4_reg.a <= p4_reg.side.v))

endmodule
